// ===== hw/rtl/smus_pkg.sv =====
// Shared types, constants and saturation helpers for the segment map usage statistics unit.
package smus_pkg;

   localparam int ADDR_BITS_DEFAULT  = 24;
   localparam int COUNT_BITS_DEFAULT = 16;
   localparam int KB_SHIFT           = 10;
   localparam int CSR_ADDR_BITS      = 3;
   localparam int CSR_DATA_BITS      = 32;

   // register select, taken from paddr[2]
   localparam logic CSR_REG_CORE_BOTTOM = 1'b0;
   localparam logic CSR_REG_CORE_TOP    = 1'b1;

   typedef struct packed {
      logic        end_of_queue;
      logic [23:0] seg_start;
      logic [23:0] seg_bytes;
      logic        is_shared_text;
      logic        is_stack;
      logic        is_system;
      logic [7:0]  ref_count;
   } smus_req_type;

   typedef struct packed {
      logic [13:0] total_kb;
      logic [13:0] used_kb;
      logic [13:0] free_kb;
      logic [13:0] shared_kb;
      logic [21:0] saved_kb;
      logic [13:0] stack_kb;
      logic [13:0] system_kb;
      logic [13:0] largest_hole_kb;
      logic [15:0] segment_count;
      logic [15:0] shared_count;
      logic [15:0] hole_count;
      logic        changed;
   } smus_rsp_type;

   // Walk figures after the current item, counts already capped to 16 bits.
   typedef struct packed {
      logic [31:0] used_sum;
      logic [31:0] shared_sum;
      logic [39:0] saved_sum;
      logic [31:0] stack_sum;
      logic [31:0] system_sum;
      logic [13:0] hole_kb;
      logic [15:0] seg_count;
      logic [15:0] shr_count;
      logic [15:0] hole_count;
   } smus_stats_type;

   function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? '1 : s[31:0];
   endfunction

   function automatic logic [39:0] sat_add40(input logic [39:0] a, input logic [39:0] b);
      logic [40:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[40] ? '1 : s[39:0];
   endfunction

   function automatic logic [13:0] cap14(input logic [31:0] v);
      return (|v[31:14]) ? '1 : v[13:0];
   endfunction

   function automatic logic [15:0] cap16(input logic [31:0] v);
      return (|v[31:16]) ? '1 : v[15:0];
   endfunction

   function automatic logic [21:0] cap22(input logic [31:0] v);
      return (|v[31:22]) ? '1 : v[21:0];
   endfunction

endpackage

// ===== hw/rtl/smus_csr.sv =====
// Configuration registers core_bottom and core_top behind the APB-style port.
module smus_csr #(
   parameter int ADDR_BITS = smus_pkg::ADDR_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [smus_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [smus_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [smus_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                                pready,
   output logic [ADDR_BITS-1:0]                core_bottom,
   output logic [ADDR_BITS-1:0]                core_top
);

   logic [ADDR_BITS-1:0] bottom_ff, bottom_in;
   logic [ADDR_BITS-1:0] top_ff, top_in;
   logic                 wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   always_comb begin
      bottom_in = bottom_ff;
      top_in    = top_ff;
      if (wr_en) begin
         case (paddr[2])
            smus_pkg::CSR_REG_CORE_BOTTOM: bottom_in = ADDR_BITS'(pwdata);
            smus_pkg::CSR_REG_CORE_TOP:    top_in    = ADDR_BITS'(pwdata);
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         smus_pkg::CSR_REG_CORE_BOTTOM: prdata = smus_pkg::CSR_DATA_BITS'(bottom_ff);
         smus_pkg::CSR_REG_CORE_TOP:    prdata = smus_pkg::CSR_DATA_BITS'(top_ff);
         default:                       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bottom_ff <= '0;
         top_ff    <= '0;
      end else begin
         bottom_ff <= bottom_in;
         top_ff    <= top_in;
      end
   end

   assign core_bottom = bottom_ff;
   assign core_top    = top_ff;

endmodule

// ===== hw/rtl/smus_accum.sv =====
// Walk accumulators: byte sums, counts, hole tracking and previous segment end.
module smus_accum #(
   parameter int ADDR_BITS  = smus_pkg::ADDR_BITS_DEFAULT,
   parameter int COUNT_BITS = smus_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [ADDR_BITS-1:0]     core_bottom,
   input  logic [ADDR_BITS-1:0]     core_top,
   input  logic                     item_go,
   input  smus_pkg::smus_req_type   item,
   output smus_pkg::smus_stats_type stats
);

   logic [ADDR_BITS:0]   prev_end_ff, prev_end_in;
   logic                 started_ff;
   logic [31:0]          used_ff, used_in;
   logic [31:0]          shared_ff, shared_in;
   logic [39:0]          saved_ff, saved_in;
   logic [31:0]          stack_ff, stack_in;
   logic [31:0]          system_ff, system_in;
   logic [ADDR_BITS-1:0] big_ff, big_in;
   logic [COUNT_BITS-1:0] seg_cnt_ff, seg_cnt_in;
   logic [COUNT_BITS-1:0] shr_cnt_ff, shr_cnt_in;
   logic [COUNT_BITS-1:0] gap_cnt_ff, gap_cnt_in;

   logic [ADDR_BITS-1:0] start;
   logic [ADDR_BITS-1:0] bytes;
   logic [ADDR_BITS:0]   prev;
   logic [ADDR_BITS:0]   target;
   logic                 gap_hit;
   logic [ADDR_BITS-1:0] gap;
   logic [7:0]           refs_m1;
   logic [ADDR_BITS+7:0] saved_prod;
   logic                 is_seg;
   logic                 is_shr;

   always_comb begin
      start      = ADDR_BITS'(item.seg_start);
      bytes      = ADDR_BITS'(item.seg_bytes);
      is_seg     = !item.end_of_queue;
      is_shr     = is_seg && item.is_shared_text;
      prev       = started_ff ? prev_end_ff : {1'b0, core_bottom};
      // the end marker closes the walk against core top
      target     = item.end_of_queue ? {1'b0, core_top} : {1'b0, start};
      gap_hit    = target > prev;
      gap        = ADDR_BITS'(target - prev);
      refs_m1    = item.ref_count - 8'd1;
      saved_prod = (ADDR_BITS+8)'(refs_m1) * (ADDR_BITS+8)'(bytes);
      prev_end_in = {1'b0, start} + {1'b0, bytes};

      gap_cnt_in = (gap_hit && gap_cnt_ff != '1) ? gap_cnt_ff + COUNT_BITS'(1) : gap_cnt_ff;
      big_in     = (gap_hit && gap > big_ff) ? gap : big_ff;
      seg_cnt_in = (is_seg && seg_cnt_ff != '1) ? seg_cnt_ff + COUNT_BITS'(1) : seg_cnt_ff;
      shr_cnt_in = (is_shr && shr_cnt_ff != '1) ? shr_cnt_ff + COUNT_BITS'(1) : shr_cnt_ff;
      used_in    = is_seg ? smus_pkg::sat_add32(used_ff, 32'(bytes)) : used_ff;
      shared_in  = is_shr ? smus_pkg::sat_add32(shared_ff, 32'(bytes)) : shared_ff;
      saved_in   = (is_shr && item.ref_count > 8'd1)
                   ? smus_pkg::sat_add40(saved_ff, 40'(saved_prod)) : saved_ff;
      stack_in   = (is_seg && item.is_stack)
                   ? smus_pkg::sat_add32(stack_ff, 32'(bytes)) : stack_ff;
      system_in  = (is_seg && item.is_system)
                   ? smus_pkg::sat_add32(system_ff, 32'(bytes)) : system_ff;

      stats.used_sum   = used_in;
      stats.shared_sum = shared_in;
      stats.saved_sum  = saved_in;
      stats.stack_sum  = stack_in;
      stats.system_sum = system_in;
      stats.hole_kb    = smus_pkg::cap14(32'(big_in >> smus_pkg::KB_SHIFT));
      stats.seg_count  = smus_pkg::cap16(32'(seg_cnt_in));
      stats.shr_count  = smus_pkg::cap16(32'(shr_cnt_in));
      stats.hole_count = smus_pkg::cap16(32'(gap_cnt_in));
   end

   always_ff @(posedge clock) begin
      if (reset || (item_go && item.end_of_queue)) begin
         prev_end_ff <= '0;
         started_ff  <= 1'b0;
         used_ff     <= '0;
         shared_ff   <= '0;
         saved_ff    <= '0;
         stack_ff    <= '0;
         system_ff   <= '0;
         big_ff      <= '0;
         seg_cnt_ff  <= '0;
         shr_cnt_ff  <= '0;
         gap_cnt_ff  <= '0;
      end else if (item_go) begin
         prev_end_ff <= prev_end_in;
         started_ff  <= 1'b1;
         used_ff     <= used_in;
         shared_ff   <= shared_in;
         saved_ff    <= saved_in;
         stack_ff    <= stack_in;
         system_ff   <= system_in;
         big_ff      <= big_in;
         seg_cnt_ff  <= seg_cnt_in;
         shr_cnt_ff  <= shr_cnt_in;
         gap_cnt_ff  <= gap_cnt_in;
      end
   end

endmodule

// ===== hw/rtl/smus_report.sv =====
// Report formatting in Kb, change detection against the last report, result register.
module smus_report #(
   parameter int ADDR_BITS = smus_pkg::ADDR_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [ADDR_BITS-1:0]     core_bottom,
   input  logic [ADDR_BITS-1:0]     core_top,
   input  logic                     load,
   input  smus_pkg::smus_stats_type stats,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output smus_pkg::smus_rsp_type   rsp_payload
);

   typedef struct packed {
      logic [13:0] total_kb;
      logic [13:0] used_kb;
      logic [13:0] hole_kb;
      logic [13:0] shared_kb;
      logic [13:0] stack_kb;
      logic [13:0] system_kb;
      logic [15:0] seg_count;
   } key_type;

   logic                   out_valid_ff, out_valid_in;
   smus_pkg::smus_rsp_type out_ff, out_in;
   key_type                last_ff, last_in;
   logic [ADDR_BITS-1:0]   span;

   always_comb begin
      span = core_top - core_bottom;
      out_in.total_kb = (core_top > core_bottom)
                        ? smus_pkg::cap14(32'(span >> smus_pkg::KB_SHIFT)) : '0;
      out_in.used_kb   = smus_pkg::cap14(32'(stats.used_sum[31:10]));
      out_in.free_kb   = (out_in.total_kb > out_in.used_kb)
                         ? out_in.total_kb - out_in.used_kb : '0;
      out_in.shared_kb = smus_pkg::cap14(32'(stats.shared_sum[31:10]));
      out_in.saved_kb  = smus_pkg::cap22(32'(stats.saved_sum[39:10]));
      out_in.stack_kb  = smus_pkg::cap14(32'(stats.stack_sum[31:10]));
      out_in.system_kb = smus_pkg::cap14(32'(stats.system_sum[31:10]));
      out_in.largest_hole_kb = stats.hole_kb;
      out_in.segment_count   = stats.seg_count;
      out_in.shared_count    = stats.shr_count;
      out_in.hole_count      = stats.hole_count;

      last_in.total_kb  = out_in.total_kb;
      last_in.used_kb   = out_in.used_kb;
      last_in.hole_kb   = out_in.largest_hole_kb;
      last_in.shared_kb = out_in.shared_kb;
      last_in.stack_kb  = out_in.stack_kb;
      last_in.system_kb = out_in.system_kb;
      last_in.seg_count = out_in.segment_count;
      out_in.changed    = (last_in != last_ff);

      // hold until taken, a new load replaces a taken one
      out_valid_in = load | (out_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         last_ff      <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (load) begin
            last_ff <= last_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

// ===== hw/rtl/segment_map_usage_stats_unit.sv =====
// Top level of the segment map usage statistics unit: input register and handshake control.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  smus_req_type (segment or end marker)
//   rsp      out        rsp_valid / rsp_ready  smus_rsp_type (one report per end marker)
//   csr      in/out     psel/penable/pwrite    core_bottom at 0x0, core_top at 0x4
//
// One item per cycle while no end marker stalls: an item is held in the input
// register, and its accumulator update is a single pass of adds, one 8 x ADDR_BITS
// multiply and compares. A report loads into the result register at the edge at
// which the end marker leaves the input register.
// Synchronous reset clears the walk and the last report.
// Segment items keep flowing while a report waits; an end marker stalls only
// while the previous report is still held in the result register.
module segment_map_usage_stats_unit #(
   parameter int ADDR_BITS  = smus_pkg::ADDR_BITS_DEFAULT,
   parameter int COUNT_BITS = smus_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  smus_pkg::smus_req_type             req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output smus_pkg::smus_rsp_type             rsp_payload,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [smus_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [smus_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [smus_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                               pready
);

   logic                     s1_valid_ff, s1_valid_in;
   smus_pkg::smus_req_type   s1_ff;
   logic                     s1_go;
   logic [ADDR_BITS-1:0]     core_bottom;
   logic [ADDR_BITS-1:0]     core_top;
   smus_pkg::smus_stats_type stats;

   smus_csr #(
      .ADDR_BITS (ADDR_BITS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .core_bottom (core_bottom),
      .core_top    (core_top)
   );

   // advance the held item unless it is an end marker blocked by a waiting report
   always_comb begin
      s1_go       = s1_valid_ff & (~s1_ff.end_of_queue | ~rsp_valid | rsp_ready);
      req_ready   = ~s1_valid_ff | s1_go;
      s1_valid_in = req_valid | (s1_valid_ff & ~s1_go);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_ff <= req_payload;
      end
   end

   smus_accum #(
      .ADDR_BITS  (ADDR_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_accum (
      .clock       (clock),
      .reset       (reset),
      .core_bottom (core_bottom),
      .core_top    (core_top),
      .item_go     (s1_go),
      .item        (s1_ff),
      .stats       (stats)
   );

   smus_report #(
      .ADDR_BITS (ADDR_BITS)
   ) u_report (
      .clock       (clock),
      .reset       (reset),
      .core_bottom (core_bottom),
      .core_top    (core_top),
      .load        (s1_go & s1_ff.end_of_queue),
      .stats       (stats),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== test/segment_map_usage_stats_unit_tb.sv =====
// Self-checking testbench for the segment map usage statistics unit.
`timescale 1ns / 100ps

module segment_map_usage_stats_unit_tb;

   localparam int unsigned CYCLE_LIMIT    = 200000;
   localparam int unsigned IDLE_PERCENT   = 37;
   localparam int          HOLD_CYCLES    = 300;
   localparam int          PHASE_ITEMS    = 85;
   localparam int          PHASE_COUNT    = 11;
   localparam int          SATURATE_SEGS  = 300;
   localparam int          SETTLE_CYCLES  = 8;
   localparam int          NO_IDLE_PHASE  = 3;
   localparam int          HOLD_PHASE     = 5;
   localparam int          SATURATE_PHASE = 7;
   localparam int          RETUNE_PHASE   = 9;
   localparam int          EXTREME_PHASE  = 10;

   localparam logic [smus_pkg::CSR_ADDR_BITS-1:0] CORE_BOTTOM_ADDR =
      {smus_pkg::CSR_REG_CORE_BOTTOM, 2'b00};
   localparam logic [smus_pkg::CSR_ADDR_BITS-1:0] CORE_TOP_ADDR    =
      {smus_pkg::CSR_REG_CORE_TOP, 2'b00};

   localparam longint unsigned KB_CAP_14  = 16383;
   localparam longint unsigned KB_CAP_22  = 4194303;
   localparam longint unsigned SUM_CAP_32 = 64'hFFFF_FFFF;
   localparam longint unsigned SUM_CAP_40 = 64'hFF_FFFF_FFFF;

   typedef enum logic {ROW_CSR, ROW_ITEM} row_kind_type;

   typedef enum int {
      SPAN_RANDOM_LOW, SPAN_EMPTY, SPAN_INVERTED, SPAN_FULL, SPAN_REVERSED_EXTREMES, SPAN_ANY
   } span_style_type;

   typedef struct packed {
      row_kind_type                       kind;
      logic [smus_pkg::CSR_ADDR_BITS-1:0] csr_addr;
      logic [23:0]                        csr_value;
      smus_pkg::smus_req_type             item;
      logic                               typed;
      smus_pkg::smus_rsp_type             want;
   } stim_row_type;

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               req_valid;
   logic                               req_ready;
   smus_pkg::smus_req_type             req_payload;
   logic                               rsp_valid;
   logic                               rsp_ready;
   smus_pkg::smus_rsp_type             rsp_payload;
   logic                               psel;
   logic                               penable;
   logic                               pwrite;
   logic [smus_pkg::CSR_ADDR_BITS-1:0] paddr;
   logic [smus_pkg::CSR_DATA_BITS-1:0] pwdata;
   logic [smus_pkg::CSR_DATA_BITS-1:0] prdata;
   logic                               pready;

   // usage predictor state
   logic [23:0]  cfg_bottom;
   logic [23:0]  cfg_top;
   logic [24:0]  walk_prev_end;
   logic         walk_open;
   logic [31:0]  used_acc;
   logic [31:0]  shared_acc;
   logic [39:0]  saved_acc;
   logic [31:0]  stack_acc;
   logic [31:0]  system_acc;
   logic [23:0]  widest_gap;
   logic [15:0]  seg_tally;
   logic [15:0]  shr_tally;
   logic [15:0]  gap_tally;
   logic [99:0]  prior_figures;

   smus_pkg::smus_rsp_type pending_reports[$];
   smus_pkg::smus_req_type walk_log[$];
   stim_row_type           directed_rows[$];

   int           mismatches = 0;
   int           items_sent = 0;
   int unsigned  cycle_count = 0;
   bit           tx_idle_on = 1'b1;
   bit           rx_idle_on = 1'b1;
   int           hold_request = 0;
   int           hold_left = 0;

   segment_map_usage_stats_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("segment_map_usage_stats_unit: mismatch");
         $finish;
      end
   end

   function automatic longint unsigned clamp_add(input longint unsigned a,
                                                 input longint unsigned b,
                                                 input longint unsigned ceiling);
      longint unsigned s;
      s = a + b;
      return (s > ceiling) ? ceiling : s;
   endfunction

   function automatic longint unsigned limit(input longint unsigned v,
                                             input longint unsigned ceiling);
      return (v > ceiling) ? ceiling : v;
   endfunction

   function automatic logic [15:0] bump16(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   task automatic wipe_walk();
      walk_prev_end = '0;
      walk_open     = 1'b0;
      used_acc      = '0;
      shared_acc    = '0;
      saved_acc     = '0;
      stack_acc     = '0;
      system_acc    = '0;
      widest_gap    = '0;
      seg_tally     = '0;
      shr_tally     = '0;
      gap_tally     = '0;
   endtask

   task automatic log_gap(input logic [24:0] from_addr, input logic [24:0] to_addr);
      logic [24:0] span;
      if (to_addr > from_addr) begin
         span = to_addr - from_addr;
         gap_tally = bump16(gap_tally);
         if (span > {1'b0, widest_gap}) widest_gap = span[23:0];
      end
   endtask

   // Advance the walk by one item; fill the report on an end marker.
   task automatic apply_item(input smus_pkg::smus_req_type it, output bit has_rsp,
                             output smus_pkg::smus_rsp_type rsp);
      logic [24:0]     prev;
      longint unsigned refs;
      longint unsigned span_kb;
      logic [99:0]     figures;
      prev = walk_open ? walk_prev_end : {1'b0, cfg_bottom};
      has_rsp = 1'b0;
      rsp = '0;
      if (!it.end_of_queue) begin
         seg_tally = bump16(seg_tally);
         used_acc = 32'(clamp_add(used_acc, it.seg_bytes, SUM_CAP_32));
         if (it.is_shared_text) begin
            shr_tally = bump16(shr_tally);
            shared_acc = 32'(clamp_add(shared_acc, it.seg_bytes, SUM_CAP_32));
            refs = it.ref_count;
            if (refs > 1) begin
               saved_acc = 40'(clamp_add(saved_acc, (refs - 1) * it.seg_bytes, SUM_CAP_40));
            end
         end
         if (it.is_stack) stack_acc = 32'(clamp_add(stack_acc, it.seg_bytes, SUM_CAP_32));
         if (it.is_system) system_acc = 32'(clamp_add(system_acc, it.seg_bytes, SUM_CAP_32));
         log_gap(prev, {1'b0, it.seg_start});
         walk_prev_end = {1'b0, it.seg_start} + {1'b0, it.seg_bytes};
         walk_open = 1'b1;
      end else begin
         log_gap(prev, {1'b0, cfg_top});
         span_kb = (cfg_top > cfg_bottom) ? (cfg_top - cfg_bottom) >> 10 : 0;
         rsp.total_kb        = 14'(limit(span_kb, KB_CAP_14));
         rsp.used_kb         = 14'(limit(used_acc >> 10, KB_CAP_14));
         rsp.free_kb         = (rsp.total_kb > rsp.used_kb) ? rsp.total_kb - rsp.used_kb : '0;
         rsp.shared_kb       = 14'(limit(shared_acc >> 10, KB_CAP_14));
         rsp.saved_kb        = 22'(limit(saved_acc >> 10, KB_CAP_22));
         rsp.stack_kb        = 14'(limit(stack_acc >> 10, KB_CAP_14));
         rsp.system_kb       = 14'(limit(system_acc >> 10, KB_CAP_14));
         rsp.largest_hole_kb = 14'(limit(widest_gap >> 10, KB_CAP_14));
         rsp.segment_count   = seg_tally;
         rsp.shared_count    = shr_tally;
         rsp.hole_count      = gap_tally;
         figures = {rsp.total_kb, rsp.used_kb, rsp.largest_hole_kb, rsp.shared_kb,
                    rsp.stack_kb, rsp.system_kb, rsp.segment_count};
         rsp.changed = (figures != prior_figures);
         prior_figures = figures;
         wipe_walk();
         has_rsp = 1'b1;
      end
   endtask

   task automatic check_field(input string field, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endtask

   task automatic check_report(input smus_pkg::smus_rsp_type got);
      smus_pkg::smus_rsp_type want;
      if (pending_reports.size() == 0) begin
         $error("report with nothing expected: %h", got);
         mismatches++;
         return;
      end
      want = pending_reports.pop_front();
      check_field("total_kb", want.total_kb, got.total_kb);
      check_field("used_kb", want.used_kb, got.used_kb);
      check_field("free_kb", want.free_kb, got.free_kb);
      check_field("shared_kb", want.shared_kb, got.shared_kb);
      check_field("saved_kb", want.saved_kb, got.saved_kb);
      check_field("stack_kb", want.stack_kb, got.stack_kb);
      check_field("system_kb", want.system_kb, got.system_kb);
      check_field("largest_hole_kb", want.largest_hole_kb, got.largest_hole_kb);
      check_field("segment_count", want.segment_count, got.segment_count);
      check_field("shared_count", want.shared_count, got.shared_count);
      check_field("hole_count", want.hole_count, got.hole_count);
      check_field("changed", want.changed, got.changed);
   endtask

   // Report receiver: random stalls plus a long hold-off on request.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_report(rsp_payload);
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !(rx_idle_on && $urandom_range(0, 99) < IDLE_PERCENT);
      end
   end

   task automatic push_item(input smus_pkg::smus_req_type it, input bit typed,
                            input smus_pkg::smus_rsp_type want);
      bit                     got;
      smus_pkg::smus_rsp_type calc;
      while (tx_idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= it;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      apply_item(it, got, calc);
      if (got) pending_reports.push_back(typed ? want : calc);
   endtask

   // Drop valid, wait out every report, then let the pipeline empty.
   task automatic drain_and_idle();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [smus_pkg::CSR_ADDR_BITS-1:0] addr,
                            input logic [23:0] value);
      logic [7:0] junk;
      junk = 8'($urandom);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= {junk, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (addr == CORE_BOTTOM_ADDR) cfg_bottom = value;
      else cfg_top = value;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic retarget(input span_style_type style);
      logic [23:0] bottom;
      logic [23:0] top;
      case (style)
         SPAN_RANDOM_LOW: begin
            bottom = 24'($urandom_range(0, 'h100000));
            top = bottom + 24'($urandom_range(0, 'hEFFFFF));
         end
         SPAN_EMPTY: begin
            bottom = 24'($urandom);
            top = bottom;
         end
         SPAN_INVERTED: begin
            top = 24'($urandom_range(0, 'h7FFFFF));
            bottom = top + 24'($urandom_range(1, 'h7FFFFF));
         end
         SPAN_FULL: begin
            bottom = '0;
            top = '1;
         end
         SPAN_REVERSED_EXTREMES: begin
            bottom = '1;
            top = '0;
         end
         default: begin
            bottom = 24'($urandom);
            top = 24'($urandom);
         end
      endcase
      csr_write(CORE_BOTTOM_ADDR, bottom);
      csr_write(CORE_TOP_ADDR, top);
   endtask

   function automatic logic [23:0] pick_size();
      int unsigned roll;
      logic [23:0] v;
      roll = $urandom_range(0, 99);
      if (roll < 40) v = 24'($urandom_range(0, 'h3FFF));
      else if (roll < 80) v = 24'($urandom_range(0, 'h3FFFF));
      else if (roll < 95) v = 24'($urandom);
      else v = '1;
      return v;
   endfunction

   function automatic longint unsigned step_cursor(input longint unsigned cursor);
      int unsigned roll;
      longint unsigned back;
      roll = $urandom_range(0, 99);
      if (roll < 55) return cursor;
      if (roll < 80) return cursor + $urandom_range(1, 'h3FFF);
      if (roll < 92) return cursor + $urandom_range('h4000, 'h200000);
      // overlap the previous segment
      back = $urandom_range(1, 'h2000);
      return (back > cursor) ? 0 : cursor - back;
   endfunction

   function automatic smus_pkg::smus_req_type random_segment();
      smus_pkg::smus_req_type it;
      it.end_of_queue   = 1'b0;
      it.seg_start      = 24'($urandom);
      it.seg_bytes      = pick_size();
      it.is_shared_text = 1'($urandom_range(0, 1));
      it.is_stack       = 1'($urandom_range(0, 1));
      it.is_system      = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 4))
         0: it.ref_count = 8'd0;
         1: it.ref_count = 8'd1;
         2: it.ref_count = 8'd2;
         3: it.ref_count = 8'hFF;
         default: it.ref_count = 8'($urandom);
      endcase
      return it;
   endfunction

   function automatic smus_pkg::smus_req_type end_marker(input bit junk_fields);
      smus_pkg::smus_req_type it;
      it = junk_fields ? '1 : '0;
      it.end_of_queue = 1'b1;
      return it;
   endfunction

   function automatic smus_pkg::smus_req_type seg_item(input logic [23:0] start,
                                                       input logic [23:0] bytes,
                                                       input bit shared_f, input bit stack_f,
                                                       input bit system_f,
                                                       input logic [7:0] refs);
      smus_pkg::smus_req_type it;
      it.end_of_queue   = 1'b0;
      it.seg_start      = start;
      it.seg_bytes      = bytes;
      it.is_shared_text = shared_f;
      it.is_stack       = stack_f;
      it.is_system      = system_f;
      it.ref_count      = refs;
      return it;
   endfunction

   function automatic stim_row_type csr_row(input logic [smus_pkg::CSR_ADDR_BITS-1:0] addr,
                                            input logic [23:0] value);
      stim_row_type row;
      row = '0;
      row.kind = ROW_CSR;
      row.csr_addr = addr;
      row.csr_value = value;
      return row;
   endfunction

   function automatic stim_row_type item_row(input smus_pkg::smus_req_type it, input bit typed,
                                             input smus_pkg::smus_rsp_type want);
      stim_row_type row;
      row = '0;
      row.kind = ROW_ITEM;
      row.item = it;
      row.typed = typed;
      row.want = want;
      return row;
   endfunction

   // Send a walk of segments and its end marker; optionally retune mid-walk.
   task automatic run_walk(input int seg_total, input bit tidy, input bit retune);
      smus_pkg::smus_req_type it;
      logic [63:0]            junk;
      longint unsigned        cursor;
      cursor = cfg_bottom;
      walk_log.delete();
      for (int i = 0; i < seg_total; i++) begin
         if (retune && i == seg_total / 2) begin
            drain_and_idle();
            retarget(span_style_type'($urandom_range(0, 5)));
         end
         it = random_segment();
         if (tidy) begin
            cursor = step_cursor(cursor);
            it.seg_start = cursor[23:0];
            cursor = it.seg_start + it.seg_bytes;
         end
         walk_log.push_back(it);
         push_item(it, 1'b0, '0);
      end
      junk = {$urandom, $urandom};
      it = junk[$bits(smus_pkg::smus_req_type)-1:0];
      it.end_of_queue = 1'b1;
      walk_log.push_back(it);
      push_item(it, 1'b0, '0);
   endtask

   initial begin
      smus_pkg::smus_rsp_type zero_report;
      smus_pkg::smus_rsp_type hole_report;
      smus_pkg::smus_rsp_type same_report;
      smus_pkg::smus_rsp_type inverted_report;
      smus_pkg::smus_req_type replay_buf[$];
      smus_pkg::smus_req_type it;
      longint unsigned        cursor;
      int                     phase_start;
      int unsigned            roll;
      bit                     retuned;

      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      rsp_ready   <= 1'b0;
      psel        <= 1'b0;
      penable     <= 1'b0;
      pwrite      <= 1'b0;
      paddr       <= '0;
      pwdata      <= '0;
      cfg_bottom    = '0;
      cfg_top       = '0;
      prior_figures = '0;
      wipe_walk();

      zero_report = '0;
      hole_report = '0;
      hole_report.total_kb        = 14'd1024;
      hole_report.free_kb         = 14'd1024;
      hole_report.largest_hole_kb = 14'd1024;
      hole_report.hole_count      = 16'd1;
      hole_report.changed         = 1'b1;
      same_report = hole_report;
      same_report.changed = 1'b0;
      inverted_report = '0;
      inverted_report.changed = 1'b1;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      directed_rows.push_back(item_row(end_marker(1'b0), 1'b1, zero_report));
      directed_rows.push_back(item_row(end_marker(1'b1), 1'b1, zero_report));
      directed_rows.push_back(csr_row(CORE_TOP_ADDR, 24'h100000));
      directed_rows.push_back(item_row(end_marker(1'b0), 1'b1, hole_report));
      directed_rows.push_back(item_row(end_marker(1'b1), 1'b1, same_report));
      directed_rows.push_back(csr_row(CORE_BOTTOM_ADDR, 24'h800000));
      directed_rows.push_back(item_row(end_marker(1'b0), 1'b1, inverted_report));
      directed_rows.push_back(csr_row(CORE_BOTTOM_ADDR, 24'h000000));
      directed_rows.push_back(csr_row(CORE_TOP_ADDR, 24'hFFFFFF));
      directed_rows.push_back(item_row(seg_item(24'h0, 24'hFFFFFF, 1'b1, 1'b1, 1'b1, 8'hFF),
                                       1'b0, '0));
      directed_rows.push_back(item_row(end_marker(1'b0), 1'b0, '0));
      directed_rows.push_back(item_row(seg_item(24'h1000, 24'h800, 1'b0, 1'b1, 1'b0, 8'h00),
                                       1'b0, '0));
      directed_rows.push_back(item_row(seg_item(24'h1400, 24'h400, 1'b1, 1'b0, 1'b0, 8'h01),
                                       1'b0, '0));
      directed_rows.push_back(item_row(seg_item(24'h4000, 24'h2000, 1'b0, 1'b0, 1'b1, 8'h03),
                                       1'b0, '0));
      directed_rows.push_back(item_row(seg_item(24'h6000, 24'h0, 1'b1, 1'b0, 1'b0, 8'h02),
                                       1'b0, '0));
      directed_rows.push_back(item_row(seg_item(24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b0, 1'b0,
                                                8'hC8), 1'b0, '0));
      directed_rows.push_back(item_row(seg_item(24'h800000, 24'h10, 1'b0, 1'b0, 1'b0, 8'h00),
                                       1'b0, '0));
      directed_rows.push_back(item_row(end_marker(1'b0), 1'b0, '0));
      directed_rows.push_back(item_row(seg_item(24'h20000, 24'h1000, 1'b0, 1'b0, 1'b0, 8'h00),
                                       1'b0, '0));
      // move the window while a walk is open
      directed_rows.push_back(csr_row(CORE_BOTTOM_ADDR, 24'h040000));
      directed_rows.push_back(csr_row(CORE_TOP_ADDR, 24'h080000));
      directed_rows.push_back(item_row(seg_item(24'h30000, 24'h400, 1'b0, 1'b1, 1'b1, 8'h00),
                                       1'b0, '0));
      directed_rows.push_back(item_row(end_marker(1'b0), 1'b0, '0));
      directed_rows.push_back(item_row(seg_item(24'h10, 24'h400, 1'b1, 1'b0, 1'b0, 8'h05),
                                       1'b0, '0));
      directed_rows.push_back(item_row(end_marker(1'b1), 1'b0, '0));

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            drain_and_idle();
            csr_write(directed_rows[i].csr_addr, directed_rows[i].csr_value);
         end else begin
            push_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
         end
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         drain_and_idle();
         if (phase == 0 || phase == SATURATE_PHASE) retarget(SPAN_FULL);
         else if (phase == EXTREME_PHASE) retarget(SPAN_REVERSED_EXTREMES);
         else if ($urandom_range(0, 1) == 0) retarget(SPAN_RANDOM_LOW);
         else retarget(span_style_type'($urandom_range(0, 5)));
         tx_idle_on = (phase != NO_IDLE_PHASE && phase != HOLD_PHASE);
         rx_idle_on = (phase != NO_IDLE_PHASE);
         if (phase == HOLD_PHASE) hold_request = HOLD_CYCLES;
         walk_log.delete();
         retuned = 1'b0;
         phase_start = items_sent;

         if (phase == SATURATE_PHASE) begin
            // big shared segments to pin the used, shared and saved sums at their ceilings
            cursor = 0;
            for (int i = 0; i < SATURATE_SEGS; i++) begin
               it = random_segment();
               it.seg_bytes = 24'($urandom_range('hF00000, 'hFFFFFF));
               it.is_shared_text = 1'b1;
               it.ref_count = 8'hFF;
               cursor = step_cursor(cursor);
               it.seg_start = cursor[23:0];
               cursor = it.seg_start + it.seg_bytes;
               push_item(it, 1'b0, '0);
            end
            push_item(end_marker(1'b0), 1'b0, '0);
         end

         while (items_sent - phase_start < PHASE_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (phase == RETUNE_PHASE && !retuned) begin
               run_walk(6, 1'b1, 1'b1);
               retuned = 1'b1;
            end else if (roll < 15 && walk_log.size() != 0) begin
               replay_buf = walk_log;
               foreach (replay_buf[i]) push_item(replay_buf[i], 1'b0, '0);
            end else if (roll < 25) begin
               run_walk($urandom_range(0, 8), 1'b0, 1'b0);
            end else if (phase == HOLD_PHASE) begin
               run_walk($urandom_range(0, 2), 1'b1, 1'b0);
            end else begin
               run_walk($urandom_range(0, 8), 1'b1, 1'b0);
            end
         end
      end

      drain_and_idle();
      if (mismatches == 0) begin
         $display("segment_map_usage_stats_unit: match");
      end else begin
         $display("segment_map_usage_stats_unit: mismatch");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/smus_pkg.sv
hw/rtl/smus_csr.sv
hw/rtl/smus_accum.sv
hw/rtl/smus_report.sv
hw/rtl/segment_map_usage_stats_unit.sv
test/segment_map_usage_stats_unit_tb.sv
